// File: rtl/cptg_pkg.sv
`default_nettype none

package cptg_pkg;

  // Field widths
  localparam int CMD_W      = 3;
  localparam int DUR_W      = 16;
  localparam int BURST_W    = 8;
  localparam int DIGIT_W    = 4;
  localparam int SAMPLE_W   = 8;
  localparam int INC_W      = 31;
  localparam int STEP_INC_W = 27;
  localparam int CAD_W      = 16;
  localparam int PHASE_W    = 32;
  localparam int COUNT_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int SINE_W     = 16;
  // duration times samples per ms, wide enough for rates up to 32 samples per ms
  localparam int LEN_PROD_W = 21;

  localparam int DEF_SINE_ENTRIES   = 1024;
  localparam int DEF_SAMPLES_PER_MS = 8;

  localparam logic [SAMPLE_W-1:0] LEVEL_MID = 8'd128;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DIAL  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BUSY  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIGIT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIAL_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAL_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CADENCE    = 3'd5;

  // Register reset values
  localparam logic [INC_W-1:0]      RST_DIAL_LOW   = 31'd187904819;
  localparam logic [INC_W-1:0]      RST_DIAL_HIGH  = 31'd236223201;
  localparam logic [INC_W-1:0]      RST_BUSY       = 31'd214748365;
  localparam logic [INC_W-1:0]      RST_DIGIT_BASE = 31'd214748365;
  localparam logic [STEP_INC_W-1:0] RST_DIGIT_STEP = 27'd21474836;
  localparam logic [CAD_W-1:0]      RST_CADENCE    = 16'd3000;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_DIAL  = 2'd1,
    MODE_BUSY  = 2'd2,
    MODE_DIGIT = 2'd3
  } mode_t;

  // How the sample of an item is formed in the output stage
  typedef enum logic [1:0] {
    KIND_SILENT = 2'd0,
    KIND_DUAL   = 2'd1,
    KIND_SINGLE = 2'd2,
    KIND_HOLD   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  active;
  } sample_ctl_t;

  typedef struct packed {
    logic [INC_W-1:0]      dial_low;
    logic [INC_W-1:0]      dial_high;
    logic [INC_W-1:0]      busy;
    logic [INC_W-1:0]      digit_base;
    logic [STEP_INC_W-1:0] digit_step;
    logic [CAD_W-1:0]      cadence;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/cptg_ctrl.sv
`default_nettype none

module cptg_ctrl #(
  parameter int SAMPLES_PER_MS = cptg_pkg::DEF_SAMPLES_PER_MS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           accept,
  input  wire logic [cptg_pkg::CMD_W-1:0]     command,
  input  wire logic [cptg_pkg::DUR_W-1:0]     duration_ms,
  input  wire logic [cptg_pkg::BURST_W-1:0]   burst_count,
  input  wire logic [cptg_pkg::DIGIT_W-1:0]   digit_value,
  input  wire cptg_pkg::cfg_t                 cfg,
  output cptg_pkg::sample_ctl_t               ctl,
  output logic [cptg_pkg::PHASE_W-1:0]        phase_a,
  output logic [cptg_pkg::PHASE_W-1:0]        phase_b
);

  localparam int LW = cptg_pkg::LEN_PROD_W;

  cptg_pkg::mode_t                     mode_r, mode_nxt;
  logic [cptg_pkg::PHASE_W-1:0]        phase_a_r, phase_a_nxt;
  logic [cptg_pkg::PHASE_W-1:0]        phase_b_r, phase_b_nxt;
  logic [cptg_pkg::PHASE_W-1:0]        step_r, step_nxt;
  logic [cptg_pkg::COUNT_W-1:0]        elapsed_r, elapsed_nxt;
  logic [cptg_pkg::COUNT_W-1:0]        length_r, length_nxt;
  logic [cptg_pkg::BURST_W-1:0]        bursts_r, bursts_nxt;
  logic                                rest_r, rest_nxt;

  logic [LW-1:0]                       len_prod;
  logic [cptg_pkg::COUNT_W-1:0]        len_samples;
  logic [cptg_pkg::INC_W-1:0]          digit_prod;
  logic [cptg_pkg::CAD_W-1:0]          cad_eff;
  logic [cptg_pkg::COUNT_W-1:0]        elapsed_inc;

  assign len_prod    = LW'(duration_ms) * LW'(SAMPLES_PER_MS);
  assign len_samples = len_prod[cptg_pkg::COUNT_W-1:0];
  assign digit_prod  = cptg_pkg::INC_W'(digit_value) * cptg_pkg::INC_W'(cfg.digit_step);
  assign cad_eff     = (cfg.cadence == '0) ? cptg_pkg::CAD_W'(1) : cfg.cadence;
  assign elapsed_inc = elapsed_r + cptg_pkg::COUNT_W'(1);

  // Next state
  always_comb begin
    mode_nxt    = mode_r;
    phase_a_nxt = phase_a_r;
    phase_b_nxt = phase_b_r;
    step_nxt    = step_r;
    elapsed_nxt = elapsed_r;
    length_nxt  = length_r;
    bursts_nxt  = bursts_r;
    rest_nxt    = rest_r;
    unique case (command)
      cptg_pkg::CMD_TICK: begin
        if (mode_r != cptg_pkg::MODE_IDLE) begin
          elapsed_nxt = elapsed_inc;
          if (mode_r == cptg_pkg::MODE_DIAL) begin
            phase_a_nxt = phase_a_r + step_r;
            phase_b_nxt = phase_b_r + {1'b0, cfg.dial_high};
          end else if (mode_r == cptg_pkg::MODE_DIGIT || !rest_r) begin
            phase_a_nxt = phase_a_r + step_r;
          end
          if (mode_r == cptg_pkg::MODE_BUSY) begin
            if (elapsed_inc >= {4'b0, cad_eff}) begin
              elapsed_nxt = '0;
              if (!rest_r) begin
                rest_nxt = 1'b1;
              end else begin
                // end of a rest: next burst restarts from phase zero
                rest_nxt    = 1'b0;
                phase_a_nxt = '0;
                bursts_nxt  = bursts_r - cptg_pkg::BURST_W'(1);
                if (bursts_r == cptg_pkg::BURST_W'(1)) begin
                  mode_nxt = cptg_pkg::MODE_IDLE;
                end
              end
            end
          end else if (elapsed_inc >= length_r) begin
            mode_nxt = cptg_pkg::MODE_IDLE;
          end
        end
      end
      cptg_pkg::CMD_DIAL: begin
        phase_a_nxt = '0;
        phase_b_nxt = '0;
        elapsed_nxt = '0;
        rest_nxt    = 1'b0;
        step_nxt    = {1'b0, cfg.dial_low};
        length_nxt  = len_samples;
        mode_nxt    = (len_samples == '0) ? cptg_pkg::MODE_IDLE : cptg_pkg::MODE_DIAL;
      end
      cptg_pkg::CMD_BUSY: begin
        phase_a_nxt = '0;
        phase_b_nxt = '0;
        elapsed_nxt = '0;
        rest_nxt    = 1'b0;
        step_nxt    = {1'b0, cfg.busy};
        length_nxt  = '0;
        bursts_nxt  = burst_count;
        mode_nxt    = (burst_count == '0) ? cptg_pkg::MODE_IDLE : cptg_pkg::MODE_BUSY;
      end
      cptg_pkg::CMD_DIGIT: begin
        phase_a_nxt = '0;
        phase_b_nxt = '0;
        elapsed_nxt = '0;
        rest_nxt    = 1'b0;
        step_nxt    = {1'b0, cfg.digit_base} + {1'b0, digit_prod};
        length_nxt  = len_samples;
        mode_nxt    = (len_samples == '0) ? cptg_pkg::MODE_IDLE : cptg_pkg::MODE_DIGIT;
      end
      cptg_pkg::CMD_STOP: begin
        mode_nxt = cptg_pkg::MODE_IDLE;
      end
      default: begin
      end
    endcase
  end

  // Outputs: sample form of this item, from the state before the update
  always_comb begin
    ctl.kind   = cptg_pkg::KIND_SILENT;
    ctl.active = 1'b0;
    unique case (command)
      cptg_pkg::CMD_TICK: begin
        ctl.active = (mode_r != cptg_pkg::MODE_IDLE);
        unique case (mode_r)
          cptg_pkg::MODE_DIAL:  ctl.kind = cptg_pkg::KIND_DUAL;
          cptg_pkg::MODE_DIGIT: ctl.kind = cptg_pkg::KIND_SINGLE;
          cptg_pkg::MODE_BUSY:
            ctl.kind = rest_r ? cptg_pkg::KIND_SILENT : cptg_pkg::KIND_SINGLE;
          default:              ctl.kind = cptg_pkg::KIND_SILENT;
        endcase
      end
      cptg_pkg::CMD_DIAL, cptg_pkg::CMD_DIGIT: ctl.active = (len_samples != '0);
      cptg_pkg::CMD_BUSY:                     ctl.active = (burst_count != '0);
      cptg_pkg::CMD_STOP:                     ctl.active = 1'b0;
      default: begin
        ctl.kind   = cptg_pkg::KIND_HOLD;
        ctl.active = (mode_r != cptg_pkg::MODE_IDLE);
      end
    endcase
  end

  assign phase_a = phase_a_r;
  assign phase_b = phase_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= cptg_pkg::MODE_IDLE;
      phase_a_r <= '0;
      phase_b_r <= '0;
      step_r    <= '0;
      elapsed_r <= '0;
      length_r  <= '0;
      bursts_r  <= '0;
      rest_r    <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      phase_a_r <= phase_a_nxt;
      phase_b_r <= phase_b_nxt;
      step_r    <= step_nxt;
      elapsed_r <= elapsed_nxt;
      length_r  <= length_nxt;
      bursts_r  <= bursts_nxt;
      rest_r    <= rest_nxt;
    end
  end

  a_busy_has_bursts: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == cptg_pkg::MODE_BUSY |-> bursts_r != '0)
    else $error("busy mode with no bursts left");

  a_timed_within_length: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == cptg_pkg::MODE_DIAL || mode_r == cptg_pkg::MODE_DIGIT)
      |-> elapsed_r < length_r)
    else $error("timed tone ran past its length");

  a_stop_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && command == cptg_pkg::CMD_STOP |=> mode_r == cptg_pkg::MODE_IDLE)
    else $error("stop did not idle the block");

endmodule

`default_nettype wire

// File: rtl/cptg_sine_rom.sv
`default_nettype none

module cptg_sine_rom #(
  parameter int SINE_ENTRIES = cptg_pkg::DEF_SINE_ENTRIES
) (
  input  wire logic                               clk,
  input  wire logic                               rd_en,
  input  wire logic [cptg_pkg::PHASE_W-1:0]       phase_a,
  input  wire logic [cptg_pkg::PHASE_W-1:0]       phase_b,
  output logic signed [cptg_pkg::SINE_W-1:0]      sine_a,
  output logic signed [cptg_pkg::SINE_W-1:0]      sine_b
);

  localparam int IDX_W  = $clog2(SINE_ENTRIES);
  localparam int PROD_W = 16 + IDX_W;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [cptg_pkg::SINE_W-1:0] rom_t [SINE_ENTRIES];

  // Taylor series in Q30, x in 0..pi/2: sine when odd, cosine otherwise
  function automatic longint series_q30(longint unsigned x, logic odd);
    longint unsigned term;
    longint          sum;
    int              i;
    term = odd ? x : 64'd1073741824;
    sum  = longint'(term);
    for (i = 1; i <= 9; i++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      if (odd) begin
        case (i)
          1:       term = term / 64'd6;
          2:       term = term / 64'd20;
          3:       term = term / 64'd42;
          4:       term = term / 64'd72;
          5:       term = term / 64'd110;
          6:       term = term / 64'd156;
          7:       term = term / 64'd210;
          8:       term = term / 64'd272;
          default: term = term / 64'd342;
        endcase
      end else begin
        case (i)
          1:       term = term / 64'd2;
          2:       term = term / 64'd12;
          3:       term = term / 64'd30;
          4:       term = term / 64'd56;
          5:       term = term / 64'd90;
          6:       term = term / 64'd132;
          7:       term = term / 64'd182;
          8:       term = term / 64'd240;
          default: term = term / 64'd306;
        endcase
      end
      if (i % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  function automatic logic signed [cptg_pkg::SINE_W-1:0] sine_entry(int unsigned k);
    longint unsigned q;
    longint unsigned r;
    longint unsigned x;
    longint          v;
    longint          m;
    q = (longint'(4) * k) / SINE_ENTRIES;
    r = (longint'(4) * k) % SINE_ENTRIES;
    x = (r * HALF_PI_Q30) / SINE_ENTRIES;
    v = series_q30(x, q[0] == 1'b0);
    if (v < 0) begin
      v = 0;
    end
    m = (v + 64'sd16384) >>> 15;
    if (m > 32767) begin
      m = 32767;
    end
    if (q[1]) begin
      m = -m;
    end
    return cptg_pkg::SINE_W'(m);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    int   k;
    for (k = 0; k < SINE_ENTRIES; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [PROD_W-1:0] prod_a, prod_b;
  logic [IDX_W-1:0]  idx_a, idx_b;
  logic signed [cptg_pkg::SINE_W-1:0] sine_a_r, sine_b_r;

  // index = top 16 phase bits scaled to the table length
  assign prod_a = PROD_W'(phase_a[31:16]) * PROD_W'(SINE_ENTRIES);
  assign prod_b = PROD_W'(phase_b[31:16]) * PROD_W'(SINE_ENTRIES);
  assign idx_a  = prod_a[PROD_W-1:16];
  assign idx_b  = prod_b[PROD_W-1:16];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sine_a_r <= SINE_ROM[idx_a];
      sine_b_r <= SINE_ROM[idx_b];
    end
  end

  assign sine_a = sine_a_r;
  assign sine_b = sine_b_r;

endmodule

`default_nettype wire

// File: rtl/cptg_level.sv
`default_nettype none

module cptg_level (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               load,
  input  wire cptg_pkg::sample_ctl_t              ctl,
  input  wire logic signed [cptg_pkg::SINE_W-1:0] sine_a,
  input  wire logic signed [cptg_pkg::SINE_W-1:0] sine_b,
  output logic                                    ready,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [cptg_pkg::SAMPLE_W-1:0]           out_dac_sample,
  output logic                                    out_active
);

  logic                           a_valid_r;
  cptg_pkg::sample_ctl_t          ctl_r;
  logic                           out_valid_r;
  logic [cptg_pkg::SAMPLE_W-1:0]  out_dac_sample_r;
  logic                           out_active_r;

  logic                           b_free;
  logic                           b_load;
  logic signed [16:0]             pair_sum;
  logic signed [22:0]             single_prod;
  logic signed [7:0]              offset;
  logic signed [9:0]              level_raw;
  logic [cptg_pkg::SAMPLE_W-1:0]  level;

  assign b_free = !out_valid_r || !out_stall;
  assign b_load = a_valid_r && b_free;
  assign ready  = !a_valid_r || b_free;

  // floor(64*(a+b)/32768) = (a+b) >>> 9; floor(80*a/32768) = (80*a) >>> 15
  assign pair_sum    = {sine_a[15], sine_a} + {sine_b[15], sine_b};
  assign single_prod = $signed({{7{sine_a[15]}}, sine_a}) * 23'sd80;

  always_comb begin
    unique case (ctl_r.kind)
      cptg_pkg::KIND_DUAL:   offset = pair_sum[16:9];
      cptg_pkg::KIND_SINGLE: offset = single_prod[22:15];
      default:               offset = '0;
    endcase
    level_raw = 10'sd128 + {{2{offset[7]}}, offset};
    priority if (ctl_r.kind == cptg_pkg::KIND_HOLD) begin
      level = out_dac_sample_r;
    end else if (level_raw < 10'sd0) begin
      level = '0;
    end else if (level_raw > 10'sd255) begin
      level = 8'd255;
    end else begin
      level = level_raw[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r        <= 1'b0;
      out_valid_r      <= 1'b0;
      out_dac_sample_r <= cptg_pkg::LEVEL_MID;
    end else begin
      if (load) begin
        a_valid_r <= 1'b1;
      end else if (b_load) begin
        a_valid_r <= 1'b0;
      end
      if (b_load) begin
        out_valid_r      <= 1'b1;
        out_dac_sample_r <= level;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl_r <= ctl;
    end
    if (b_load) begin
      out_active_r <= ctl_r.active;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dac_sample = out_dac_sample_r;
  assign out_active     = out_active_r;

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !b_free |=> a_valid_r && $stable(ctl_r))
    else $error("waiting item lost in sine stage");

  a_silent_mid: assert property (@(posedge clk) disable iff (!rst_n)
    b_load && ctl_r.kind == cptg_pkg::KIND_SILENT |=> out_dac_sample_r == cptg_pkg::LEVEL_MID)
    else $error("silent item not at mid-rail");

  a_hold_keeps_level: assert property (@(posedge clk) disable iff (!rst_n)
    b_load && ctl_r.kind == cptg_pkg::KIND_HOLD |=> $stable(out_dac_sample_r))
    else $error("ignored command changed the level");

endmodule

`default_nettype wire

// File: rtl/call_progress_tone_generator.sv
// Call progress tone generator: dial tone, busy cadence and digit beeps as
// unsigned 8-bit DAC samples, one sample per tick item.
// Input channel (in_valid/in_stall): one command per item; ticks give a
// sample, start and stop commands give mid-rail 128 and set up the tone.
// Every accepted item yields exactly one result item on the out_ channel
// (out_valid/out_stall) carrying out_dac_sample and out_active.
// Configuration (cfg_valid/cfg_ready, always ready) writes the phase steps
// and busy cadence by index; write only while no item is in flight.
// Path: an accepted item goes into a registered read of the dual-port sine
// table, then through the level arithmetic into the output register.
// Throughput: one item per cycle while out_stall is low; the tone state
// updates in the accept cycle, so back-to-back ticks need no gaps.
// Stall: a stalled result holds; one more item is taken into the sine stage,
// after which in_stall follows out_stall.
// Reset: idle, output level 128, registers back to their 350/440 Hz dial,
// 400 Hz busy and digit, 40 Hz digit step and 3000-sample cadence defaults.
`default_nettype none

module call_progress_tone_generator #(
  parameter int SINE_ENTRIES   = cptg_pkg::DEF_SINE_ENTRIES,
  parameter int SAMPLES_PER_MS = cptg_pkg::DEF_SAMPLES_PER_MS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [cptg_pkg::CMD_W-1:0]         in_command,
  input  wire logic [cptg_pkg::DUR_W-1:0]         in_duration_ms,
  input  wire logic [cptg_pkg::BURST_W-1:0]       in_burst_count,
  input  wire logic [cptg_pkg::DIGIT_W-1:0]       in_digit_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [cptg_pkg::SAMPLE_W-1:0]           out_dac_sample,
  output logic                                    out_active,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cptg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cptg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  cptg_pkg::cfg_t                         cfg_r, cfg_nxt;
  cptg_pkg::sample_ctl_t                  ctl;
  logic [cptg_pkg::PHASE_W-1:0]           phase_a, phase_b;
  logic signed [cptg_pkg::SINE_W-1:0]     sine_a, sine_b;
  logic                                   ready;
  logic                                   accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = !ready;
  assign accept    = in_valid && ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        cptg_pkg::CFG_DIAL_LOW:   cfg_nxt.dial_low   = cfg_data;
        cptg_pkg::CFG_DIAL_HIGH:  cfg_nxt.dial_high  = cfg_data;
        cptg_pkg::CFG_BUSY:       cfg_nxt.busy       = cfg_data;
        cptg_pkg::CFG_DIGIT_BASE: cfg_nxt.digit_base = cfg_data;
        cptg_pkg::CFG_DIGIT_STEP:
          cfg_nxt.digit_step = cfg_data[cptg_pkg::STEP_INC_W-1:0];
        cptg_pkg::CFG_CADENCE:    cfg_nxt.cadence    = cfg_data[cptg_pkg::CAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dial_low   <= cptg_pkg::RST_DIAL_LOW;
      cfg_r.dial_high  <= cptg_pkg::RST_DIAL_HIGH;
      cfg_r.busy       <= cptg_pkg::RST_BUSY;
      cfg_r.digit_base <= cptg_pkg::RST_DIGIT_BASE;
      cfg_r.digit_step <= cptg_pkg::RST_DIGIT_STEP;
      cfg_r.cadence    <= cptg_pkg::RST_CADENCE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cptg_ctrl #(
    .SAMPLES_PER_MS(SAMPLES_PER_MS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .duration_ms(in_duration_ms),
    .burst_count(in_burst_count),
    .digit_value(in_digit_value),
    .cfg        (cfg_r),
    .ctl        (ctl),
    .phase_a    (phase_a),
    .phase_b    (phase_b)
  );

  cptg_sine_rom #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_sine_rom (
    .clk    (clk),
    .rd_en  (accept),
    .phase_a(phase_a),
    .phase_b(phase_b),
    .sine_a (sine_a),
    .sine_b (sine_b)
  );

  cptg_level u_level (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (accept),
    .ctl           (ctl),
    .sine_a        (sine_a),
    .sine_b        (sine_b),
    .ready         (ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_dac_sample(out_dac_sample),
    .out_active    (out_active)
  );

endmodule

`default_nettype wire

// File: tb/cptg_checker.sv
`timescale 1ns / 1ps

module cptg_checker #(
  parameter int SINE_ENTRIES   = cptg_pkg::DEF_SINE_ENTRIES,
  parameter int SAMPLES_PER_MS = cptg_pkg::DEF_SAMPLES_PER_MS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [cptg_pkg::CMD_W-1:0]      in_command,
  input  logic [cptg_pkg::DUR_W-1:0]      in_duration_ms,
  input  logic [cptg_pkg::BURST_W-1:0]    in_burst_count,
  input  logic [cptg_pkg::DIGIT_W-1:0]    in_digit_value,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [cptg_pkg::SAMPLE_W-1:0]   out_dac_sample,
  input  logic                            out_active,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [cptg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cptg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int MAX_SHOWN = 100;

  typedef struct {
    logic [cptg_pkg::SAMPLE_W-1:0] level;
    logic                          active;
  } sample_t;

  sample_t samples_due[$];
  int      sine_rom[SINE_ENTRIES];
  int      results_seen = 0;

  cptg_pkg::cfg_t                regs;
  cptg_pkg::mode_t               mode;
  logic [cptg_pkg::PHASE_W-1:0]  phase_a, phase_b, step;
  logic [cptg_pkg::COUNT_W-1:0]  elapsed, length;
  logic [cptg_pkg::BURST_W-1:0]  bursts_left;
  logic                          resting;
  logic [cptg_pkg::SAMPLE_W-1:0] level;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  // Q30 Taylor series of sin (odd terms) or cos (even terms), x in 0..pi/2
  function automatic longint taylor_q30(longint unsigned x, bit odd_terms);
    longint unsigned term, n;
    longint          acc;
    term = odd_terms ? x : (64'd1 << 30);
    acc  = $signed(term);
    n    = odd_terms ? 1 : 0;
    for (int i = 1; i <= 9; i++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((n + 1) * (n + 2));
      n += 2;
      if (i % 2 == 1) acc -= $signed(term);
      else acc += $signed(term);
    end
    return acc;
  endfunction

  function automatic int table_entry(int unsigned k);
    int unsigned     quad, rem;
    longint unsigned x;
    longint          v;
    int              m;
    quad = (4 * k) / SINE_ENTRIES;
    rem  = (4 * k) % SINE_ENTRIES;
    x    = (64'(rem) * HALF_PI_Q30) / 64'(SINE_ENTRIES);
    v    = taylor_q30(x, quad[0] == 1'b0);
    if (v < 0) v = 0;
    m = int'((v + 64'sd16384) >>> 15);
    if (m > 32767) m = 32767;
    return quad[1] ? -m : m;
  endfunction

  initial begin
    for (int k = 0; k < SINE_ENTRIES; k++) sine_rom[k] = table_entry(k);
  end

  function automatic int sine_of(logic [cptg_pkg::PHASE_W-1:0] ph);
    longint unsigned idx;
    idx = (64'(ph[31:16]) * 64'(SINE_ENTRIES)) >> 16;
    return sine_rom[idx];
  endfunction

  // 128 + floor(v / 32768), clamped to the DAC range
  function automatic logic [cptg_pkg::SAMPLE_W-1:0] dac_of(int v);
    int s;
    s = 128 + (v >>> 15);
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return s[cptg_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic clear_tone_state();
    regs.dial_low   = cptg_pkg::RST_DIAL_LOW;
    regs.dial_high  = cptg_pkg::RST_DIAL_HIGH;
    regs.busy       = cptg_pkg::RST_BUSY;
    regs.digit_base = cptg_pkg::RST_DIGIT_BASE;
    regs.digit_step = cptg_pkg::RST_DIGIT_STEP;
    regs.cadence    = cptg_pkg::RST_CADENCE;
    mode        = cptg_pkg::MODE_IDLE;
    phase_a     = '0;
    phase_b     = '0;
    step        = '0;
    elapsed     = '0;
    length      = '0;
    bursts_left = '0;
    resting     = 1'b0;
    level       = cptg_pkg::LEVEL_MID;
  endtask

  task automatic start_tone(cptg_pkg::mode_t m, logic [cptg_pkg::PHASE_W-1:0] s,
                            logic [cptg_pkg::COUNT_W-1:0] len);
    phase_a = '0;
    phase_b = '0;
    elapsed = '0;
    resting = 1'b0;
    step    = s;
    length  = len;
    mode    = m;
    level   = cptg_pkg::LEVEL_MID;
  endtask

  task automatic predict_sample(logic [cptg_pkg::CMD_W-1:0] cmd,
                                logic [cptg_pkg::DUR_W-1:0] dur,
                                logic [cptg_pkg::BURST_W-1:0] bursts,
                                logic [cptg_pkg::DIGIT_W-1:0] digit);
    logic [cptg_pkg::COUNT_W-1:0] cad;
    logic                         act;
    sample_t                      s;
    cad = (regs.cadence == '0) ? cptg_pkg::COUNT_W'(1) : cptg_pkg::COUNT_W'(regs.cadence);
    case (cmd)
      cptg_pkg::CMD_TICK: begin
        if (mode == cptg_pkg::MODE_IDLE) begin
          level = cptg_pkg::LEVEL_MID;
          act = 1'b0;
        end else begin
          act = 1'b1;
          case (mode)
            cptg_pkg::MODE_DIAL: begin
              level = dac_of(64 * sine_of(phase_a) + 64 * sine_of(phase_b));
              phase_a += step;
              phase_b += cptg_pkg::PHASE_W'(regs.dial_high);
            end
            cptg_pkg::MODE_DIGIT: begin
              level = dac_of(80 * sine_of(phase_a));
              phase_a += step;
            end
            default: begin
              if (resting) begin
                level = cptg_pkg::LEVEL_MID;
              end else begin
                level = dac_of(80 * sine_of(phase_a));
                phase_a += step;
              end
            end
          endcase
          elapsed += 1'b1;
          if (mode == cptg_pkg::MODE_BUSY) begin
            if (elapsed >= cad) begin
              elapsed = '0;
              if (!resting) begin
                resting = 1'b1;
              end else begin
                // rest over: next burst starts from phase zero
                resting = 1'b0;
                phase_a = '0;
                bursts_left -= 1'b1;
                if (bursts_left == '0) mode = cptg_pkg::MODE_IDLE;
              end
            end
          end else if (elapsed >= length) begin
            mode = cptg_pkg::MODE_IDLE;
          end
        end
      end
      cptg_pkg::CMD_DIAL: begin
        start_tone(cptg_pkg::MODE_DIAL, cptg_pkg::PHASE_W'(regs.dial_low),
                   cptg_pkg::COUNT_W'(dur * SAMPLES_PER_MS));
        if (length == '0) mode = cptg_pkg::MODE_IDLE;
        act = (mode != cptg_pkg::MODE_IDLE);
      end
      cptg_pkg::CMD_BUSY: begin
        start_tone(cptg_pkg::MODE_BUSY, cptg_pkg::PHASE_W'(regs.busy), '0);
        bursts_left = bursts;
        if (bursts_left == '0) mode = cptg_pkg::MODE_IDLE;
        act = (mode != cptg_pkg::MODE_IDLE);
      end
      cptg_pkg::CMD_DIGIT: begin
        start_tone(cptg_pkg::MODE_DIGIT,
                   32'(regs.digit_base) + 32'(digit) * 32'(regs.digit_step),
                   cptg_pkg::COUNT_W'(dur * SAMPLES_PER_MS));
        if (length == '0) mode = cptg_pkg::MODE_IDLE;
        act = (mode != cptg_pkg::MODE_IDLE);
      end
      cptg_pkg::CMD_STOP: begin
        mode = cptg_pkg::MODE_IDLE;
        level = cptg_pkg::LEVEL_MID;
        act = 1'b0;
      end
      default: act = (mode != cptg_pkg::MODE_IDLE);
    endcase
    s.level  = level;
    s.active = act;
    samples_due.push_back(s);
  endtask

  task automatic report_diff(string msg);
    if (mismatches < MAX_SHOWN) $display("[%0t] tone check: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      clear_tone_state();
      samples_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cptg_pkg::CFG_DIAL_LOW:   regs.dial_low   = cfg_data[cptg_pkg::INC_W-1:0];
          cptg_pkg::CFG_DIAL_HIGH:  regs.dial_high  = cfg_data[cptg_pkg::INC_W-1:0];
          cptg_pkg::CFG_BUSY:       regs.busy       = cfg_data[cptg_pkg::INC_W-1:0];
          cptg_pkg::CFG_DIGIT_BASE: regs.digit_base = cfg_data[cptg_pkg::INC_W-1:0];
          cptg_pkg::CFG_DIGIT_STEP: regs.digit_step = cfg_data[cptg_pkg::STEP_INC_W-1:0];
          cptg_pkg::CFG_CADENCE:    regs.cadence    = cfg_data[cptg_pkg::CAD_W-1:0];
          default: ;
        endcase
      end
      // results first, so an item taken at this edge cannot hide a stray result
      if (out_valid && !out_stall) begin
        results_seen++;
        if (samples_due.size() == 0) begin
          report_diff($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          want = samples_due.pop_front();
          if (out_dac_sample !== want.level || out_active !== want.active)
            report_diff($sformatf("result %0d: dac_sample %0d (want %0d), active %0b (want %0b)",
                                  results_seen, out_dac_sample, want.level,
                                  out_active, want.active));
        end
      end
      if (in_valid && !in_stall)
        predict_sample(in_command, in_duration_ms, in_burst_count, in_digit_value);
    end
    outstanding = samples_due.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int ITEMS_PER_PHASE = 125;

  logic                            clk            = 1'b0;
  logic                            rst_n          = 1'b0;
  logic                            in_valid       = 1'b0;
  logic                            in_stall;
  logic [cptg_pkg::CMD_W-1:0]      in_command     = cptg_pkg::CMD_TICK;
  logic [cptg_pkg::DUR_W-1:0]      in_duration_ms = '0;
  logic [cptg_pkg::BURST_W-1:0]    in_burst_count = '0;
  logic [cptg_pkg::DIGIT_W-1:0]    in_digit_value = '0;
  logic                            out_valid;
  logic                            out_stall      = 1'b0;
  logic [cptg_pkg::SAMPLE_W-1:0]   out_dac_sample;
  logic                            out_active;
  logic                            cfg_valid      = 1'b0;
  logic                            cfg_ready;
  logic [cptg_pkg::CFG_IDX_W-1:0]  cfg_index      = cptg_pkg::CFG_DIAL_LOW;
  logic [cptg_pkg::CFG_DATA_W-1:0] cfg_data       = '0;

  int             mismatches;
  int             outstanding;
  bit             calm = 1'b0;
  bit             last_phase = 1'b0;
  int             tone_items = 0;
  int             stall_run = 0;
  bit             stall_on = 1'b0;
  cptg_pkg::cfg_t cur;

  call_progress_tone_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_duration_ms (in_duration_ms),
    .in_burst_count (in_burst_count),
    .in_digit_value (in_digit_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dac_sample (out_dac_sample),
    .out_active     (out_active),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  cptg_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_duration_ms (in_duration_ms),
    .in_burst_count (in_burst_count),
    .in_digit_value (in_digit_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dac_sample (out_dac_sample),
    .out_active     (out_active),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("call_progress_tone_generator: mismatch");
    $finish;
  end

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else begin
      if (stall_run == 0) begin
        stall_on  = ($urandom_range(0, 2) == 0);
        stall_run = $urandom_range(1, 12);
      end
      stall_run--;
      out_stall <= stall_on;
    end
  end

  task automatic send(logic [cptg_pkg::CMD_W-1:0] cmd, logic [cptg_pkg::DUR_W-1:0] dur,
                      logic [cptg_pkg::BURST_W-1:0] bursts,
                      logic [cptg_pkg::DIGIT_W-1:0] digit);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_duration_ms <= dur;
    in_burst_count <= bursts;
    in_digit_value <= digit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd <= cptg_pkg::CMD_STOP) tone_items++;
  endtask

  task automatic ticks(int n);
    repeat (n)
      send(cptg_pkg::CMD_TICK, cptg_pkg::DUR_W'($urandom), cptg_pkg::BURST_W'($urandom),
           cptg_pkg::DIGIT_W'($urandom));
  endtask

  // wait until every predicted sample has come back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(logic [cptg_pkg::CFG_IDX_W-1:0] idx,
                         logic [cptg_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(cptg_pkg::cfg_t s);
    cur = s;
    put_reg(cptg_pkg::CFG_DIAL_LOW, s.dial_low);
    put_reg(cptg_pkg::CFG_DIAL_HIGH, s.dial_high);
    put_reg(cptg_pkg::CFG_BUSY, s.busy);
    put_reg(cptg_pkg::CFG_DIGIT_BASE, s.digit_base);
    // bits above the register width are junk and must be dropped
    put_reg(cptg_pkg::CFG_DIGIT_STEP,
            cptg_pkg::CFG_DATA_W'({4'($urandom), s.digit_step}));
    put_reg(cptg_pkg::CFG_CADENCE, cptg_pkg::CFG_DATA_W'({15'($urandom), s.cadence}));
    cfg_valid <= 1'b0;
  endtask

  function automatic cptg_pkg::cfg_t random_settings(int cad_lo, int cad_hi);
    cptg_pkg::cfg_t s;
    s.dial_low   = cptg_pkg::INC_W'($urandom);
    s.dial_high  = cptg_pkg::INC_W'($urandom);
    s.busy       = cptg_pkg::INC_W'($urandom);
    s.digit_base = cptg_pkg::INC_W'($urandom);
    s.digit_step = cptg_pkg::STEP_INC_W'($urandom);
    s.cadence    = cptg_pkg::CAD_W'($urandom_range(cad_lo, cad_hi));
    return s;
  endfunction

  // one random sequence: a start command and ticks to play it out or cut it short, or noise
  task automatic play_sequence();
    int pick, n, dur, cad;
    bit cut;
    calm = last_phase || ($urandom_range(0, 5) == 0);
    cad  = (cur.cadence == 0) ? 1 : cur.cadence;
    pick = $urandom_range(0, 9);
    dur  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4);
    cut  = 1'b0;
    case (pick)
      0, 1, 2: begin
        send(cptg_pkg::CMD_DIAL, cptg_pkg::DUR_W'(dur), cptg_pkg::BURST_W'($urandom),
             cptg_pkg::DIGIT_W'($urandom));
        n = dur * cptg_pkg::DEF_SAMPLES_PER_MS + $urandom_range(0, 3);
      end
      3, 4, 5: begin
        send(cptg_pkg::CMD_DIGIT, cptg_pkg::DUR_W'(dur), cptg_pkg::BURST_W'($urandom),
             cptg_pkg::DIGIT_W'($urandom));
        n = dur * cptg_pkg::DEF_SAMPLES_PER_MS + $urandom_range(0, 3);
      end
      6, 7: begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        send(cptg_pkg::CMD_BUSY, cptg_pkg::DUR_W'($urandom), cptg_pkg::BURST_W'(n),
             cptg_pkg::DIGIT_W'($urandom));
        n = n * 2 * cad + $urandom_range(0, 3);
      end
      8: begin
        // noise, unused codes included
        repeat ($urandom_range(1, 6))
          send(cptg_pkg::CMD_W'($urandom), cptg_pkg::DUR_W'($urandom),
               cptg_pkg::BURST_W'($urandom), cptg_pkg::DIGIT_W'($urandom));
        n = 0;
      end
      default: begin
        // broken sequence: started, then cut short
        send(cptg_pkg::CMD_W'($urandom_range(cptg_pkg::CMD_DIAL, cptg_pkg::CMD_DIGIT)),
             cptg_pkg::DUR_W'($urandom), cptg_pkg::BURST_W'($urandom),
             cptg_pkg::DIGIT_W'($urandom));
        n = $urandom_range(0, 6);
        cut = 1'b1;
      end
    endcase
    if (n > 48) begin
      n = $urandom_range(4, 48);
      cut = 1'b1;
    end
    ticks(n);
    if (cut && $urandom_range(0, 1) == 0)
      send(cptg_pkg::CMD_STOP, cptg_pkg::DUR_W'($urandom), cptg_pkg::BURST_W'($urandom),
           cptg_pkg::DIGIT_W'($urandom));
  endtask

  task automatic random_phase();
    int goal;
    goal = tone_items + ITEMS_PER_PHASE;
    while (tone_items < goal) play_sequence();
    calm = last_phase;
    settle();
  endtask

  initial begin
    cptg_pkg::cfg_t s;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    ticks(1);
    send(cptg_pkg::CMD_STOP, '0, '0, '0);
    send(cptg_pkg::CMD_DIAL, '0, '1, '1);
    send(cptg_pkg::CMD_BUSY, '1, '0, '1);
    send(cptg_pkg::CMD_DIGIT, '0, '1, '1);
    send(cptg_pkg::CMD_DIAL, 16'd1, '0, '0);
    ticks(9);
    send(cptg_pkg::CMD_DIGIT, '1, '1, '1);
    ticks(2);
    send(cptg_pkg::CMD_BUSY, '0, '1, '0);
    ticks(2);
    send(cptg_pkg::CMD_STOP + 3'd1, '1, '1, '1);
    send(cptg_pkg::CMD_STOP + 3'd3, '0, '0, '0);
    send(cptg_pkg::CMD_STOP, '1, '1, '1);
    ticks(1);
    settle();

    load_settings(random_settings(1, 6));
    random_phase();

    // largest steps; cadence zero acts as one
    s.dial_low   = '1;
    s.dial_high  = '1;
    s.busy       = '1;
    s.digit_base = '1;
    s.digit_step = '1;
    s.cadence    = '0;
    load_settings(s);
    random_phase();

    s.dial_low   = '0;
    s.dial_high  = '0;
    s.busy       = '0;
    s.digit_base = '0;
    s.digit_step = '0;
    s.cadence    = cptg_pkg::CAD_W'(1);
    load_settings(s);
    random_phase();

    load_settings(random_settings(65535, 65535));
    random_phase();

    last_phase = 1'b1;
    calm = 1'b1;
    load_settings(random_settings(1, 4));
    random_phase();

    if (mismatches == 0 && outstanding == 0)
      $display("call_progress_tone_generator: match");
    else
      $display("call_progress_tone_generator: mismatch");
    $finish;
  end

endmodule
